>>> hw/rtl/subleq_pkg.sv
// Shared types, constants and the microcode ROM for the SUBLEQ processor.
// No dependencies; every other file but subleq_processor_test_pkg imports this package.
package subleq_pkg;

    localparam int MEM_DEPTH_DEF = 32768;   // words; must be a power of two
    localparam int WORD_W        = 16;
    localparam int LOAD_ADDR_W   = 15;
    localparam int CHAR_W        = 8;

    localparam logic [WORD_W-1:0] NEG_ONE = 16'hFFFF;

    // microcode step addresses
    typedef enum logic [3:0] {
        U_CLR,
        U_DISP,
        U_LOAD,
        U_HALT,
        U_FA,
        U_FB,
        U_FC,
        U_DEC,
        U_IN,
        U_OUT,
        U_RDB,
        U_WR
    } t_upc;

    typedef enum logic [1:0] {
        MEM_NONE,
        MEM_READ,
        MEM_WRITE
    } t_mem_op;

    typedef enum logic [2:0] {
        AS_PC,
        AS_PC1,
        AS_PC2,
        AS_A,
        AS_B,
        AS_LOAD,
        AS_CLR
    } t_addr_sel;

    typedef enum logic [1:0] {
        WD_ZERO,
        WD_LOAD,
        WD_INPUT,
        WD_DIFF
    } t_wd_sel;

    typedef enum logic [2:0] {
        LT_NONE,
        LT_A,
        LT_B,
        LT_C,
        LT_MA
    } t_latch;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_CLR_INC,
        ACT_LOAD_DONE,
        ACT_HALT_DONE,
        ACT_IN_DONE,
        ACT_OUT_DONE,
        ACT_SUB_DONE
    } t_act;

    typedef enum logic [1:0] {
        J_GOTO,
        J_DISPATCH,
        J_DECODE,
        J_CLR
    } t_jcond;

    typedef struct packed {
        t_mem_op   mem_op;
        t_addr_sel addr_sel;
        t_wd_sel   wd_sel;
        t_latch    latch;
        t_act      act;
        t_jcond    jcond;
        t_upc      target;
    } t_uword;

    // datapath status seen by the sequencer
    typedef struct packed {
        logic accept;
        logic req_load;
        logic halted;
        logic a_neg1;
        logic b_neg1;
        logic clr_last;
        logic hold;
    } t_seq_stat;

    function automatic t_uword rom_word(input t_upc upc);
        t_uword w;
        w = '{MEM_NONE, AS_PC, WD_ZERO, LT_NONE, ACT_NONE, J_GOTO, U_DISP};
        case (upc)
            U_CLR:  w = '{MEM_WRITE, AS_CLR,  WD_ZERO,  LT_NONE, ACT_CLR_INC,   J_CLR,      U_DISP};
            U_DISP: w = '{MEM_NONE,  AS_PC,   WD_ZERO,  LT_NONE, ACT_NONE,      J_DISPATCH, U_DISP};
            U_LOAD: w = '{MEM_WRITE, AS_LOAD, WD_LOAD,  LT_NONE, ACT_LOAD_DONE, J_GOTO,     U_DISP};
            U_HALT: w = '{MEM_NONE,  AS_PC,   WD_ZERO,  LT_NONE, ACT_HALT_DONE, J_GOTO,     U_DISP};
            U_FA:   w = '{MEM_READ,  AS_PC,   WD_ZERO,  LT_NONE, ACT_NONE,      J_GOTO,     U_FB};
            U_FB:   w = '{MEM_READ,  AS_PC1,  WD_ZERO,  LT_A,    ACT_NONE,      J_GOTO,     U_FC};
            U_FC:   w = '{MEM_READ,  AS_PC2,  WD_ZERO,  LT_B,    ACT_NONE,      J_GOTO,     U_DEC};
            U_DEC:  w = '{MEM_READ,  AS_A,    WD_ZERO,  LT_C,    ACT_NONE,      J_DECODE,   U_RDB};
            U_IN:   w = '{MEM_WRITE, AS_B,    WD_INPUT, LT_NONE, ACT_IN_DONE,   J_GOTO,     U_DISP};
            U_OUT:  w = '{MEM_NONE,  AS_PC,   WD_ZERO,  LT_NONE, ACT_OUT_DONE,  J_GOTO,     U_DISP};
            U_RDB:  w = '{MEM_READ,  AS_B,    WD_ZERO,  LT_MA,   ACT_NONE,      J_GOTO,     U_WR};
            U_WR:   w = '{MEM_WRITE, AS_B,    WD_DIFF,  LT_NONE, ACT_SUB_DONE,  J_GOTO,     U_DISP};
            default: w = '{MEM_NONE, AS_PC,   WD_ZERO,  LT_NONE, ACT_NONE,      J_GOTO,     U_DISP};
        endcase
        return w;
    endfunction

endpackage

>>> hw/rtl/subleq_if.sv
// Valid/ready channel interfaces for request and result words.
// Depends on subleq_pkg for field widths.
interface subleq_in_if;
    import subleq_pkg::*;
    logic                   valid;
    logic                   ready;
    logic                   req_type;
    logic [LOAD_ADDR_W-1:0] load_addr;
    logic [WORD_W-1:0]      load_word;
    logic [CHAR_W-1:0]      in_char;
    logic                   in_eof;

    modport source (output valid, req_type, load_addr, load_word, in_char, in_eof,
                    input ready);
    modport sink   (input valid, req_type, load_addr, load_word, in_char, in_eof,
                    output ready);
endinterface

interface subleq_out_if;
    import subleq_pkg::*;
    logic              valid;
    logic              ready;
    logic              out_valid;
    logic [CHAR_W-1:0] out_char;
    logic              in_taken;
    logic              halted;
    logic [WORD_W-1:0] next_pc;

    modport source (output valid, out_valid, out_char, in_taken, halted, next_pc,
                    input ready);
    modport sink   (input valid, out_valid, out_char, in_taken, halted, next_pc,
                    output ready);
endinterface

>>> hw/rtl/subleq_seq.sv
// Microcode sequencer: step counter, control ROM lookup and jump logic.
// Depends on subleq_pkg.
module subleq_seq (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  subleq_pkg::t_seq_stat i_stat,
    output subleq_pkg::t_uword    o_uword
);
    import subleq_pkg::*;

    t_upc   r_upc;
    t_upc   n_upc;
    t_uword uw;

    assign uw      = rom_word(r_upc);
    assign o_uword = uw;

    always_comb begin
        n_upc = r_upc;
        if (!i_stat.hold) begin
            case (uw.jcond)
                J_GOTO: n_upc = uw.target;
                J_DISPATCH: begin
                    if (i_stat.accept) begin
                        if (i_stat.req_load)
                            n_upc = U_LOAD;
                        else if (i_stat.halted)
                            n_upc = U_HALT;
                        else
                            n_upc = U_FA;
                    end
                end
                J_DECODE: begin
                    if (i_stat.a_neg1)
                        n_upc = U_IN;
                    else if (i_stat.b_neg1)
                        n_upc = U_OUT;
                    else
                        n_upc = uw.target;
                end
                J_CLR: begin
                    if (i_stat.clr_last)
                        n_upc = uw.target;
                end
                default: n_upc = U_DISP;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_upc <= U_CLR;
        else
            r_upc <= n_upc;
    end

endmodule

>>> hw/rtl/subleq_dp.sv
// Datapath: word memory, program counter, operand registers and result register.
// Driven by control words from subleq_seq; depends on subleq_pkg and subleq_if.
module subleq_dp #(
    parameter int MEM_DEPTH = subleq_pkg::MEM_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  subleq_pkg::t_uword    i_uword,
    output subleq_pkg::t_seq_stat o_stat,
    subleq_in_if.sink             i_item,
    subleq_out_if.source          o_result
);
    import subleq_pkg::*;

    localparam int AW = $clog2(MEM_DEPTH);

    logic [WORD_W-1:0] r_mem [MEM_DEPTH];
    logic [WORD_W-1:0] r_rdata;

    logic [AW-1:0]     r_clr;
    logic [WORD_W-1:0] r_pc;
    logic              r_halt;
    logic [WORD_W-1:0] r_a;
    logic [WORD_W-1:0] r_b;
    logic [WORD_W-1:0] r_c;
    logic [WORD_W-1:0] r_ma;

    logic [LOAD_ADDR_W-1:0] r_load_addr;
    logic [WORD_W-1:0]      r_load_word;
    logic [CHAR_W-1:0]      r_in_char;
    logic                   r_in_eof;

    logic              r_ov;
    logic              r_out_valid;
    logic [CHAR_W-1:0] r_out_char;
    logic              r_in_taken;
    logic              r_halted;
    logic [WORD_W-1:0] r_next_pc;

    logic              emit;
    logic              hold;
    logic              en;
    logic              accept;
    logic [WORD_W-1:0] pc1;
    logic [WORD_W-1:0] pc2;
    logic [WORD_W-1:0] pc3;
    logic [AW-1:0]     addr;
    logic [WORD_W-1:0] wdata;
    logic [WORD_W-1:0] diff;
    logic              take_jump;

    logic              res_out_valid;
    logic [CHAR_W-1:0] res_out_char;
    logic              res_in_taken;
    logic [WORD_W-1:0] res_npc;
    logic              res_pc_upd;

    assign emit = (i_uword.act == ACT_LOAD_DONE) || (i_uword.act == ACT_HALT_DONE) ||
                  (i_uword.act == ACT_IN_DONE)   || (i_uword.act == ACT_OUT_DONE)  ||
                  (i_uword.act == ACT_SUB_DONE);
    // stall a finishing step while the previous result still waits
    assign hold   = emit && r_ov && !o_result.ready;
    assign en     = !hold;
    assign accept = (i_uword.jcond == J_DISPATCH) && i_item.valid;

    assign i_item.ready = (i_uword.jcond == J_DISPATCH);

    assign o_stat.accept   = accept;
    assign o_stat.req_load = !i_item.req_type;
    assign o_stat.halted   = r_halt;
    assign o_stat.a_neg1   = (r_a == NEG_ONE);
    assign o_stat.b_neg1   = (r_b == NEG_ONE);
    assign o_stat.clr_last = (r_clr == AW'(MEM_DEPTH - 1));
    assign o_stat.hold     = hold;

    // pc stays below 32768 while running, so these never overflow 16 bits
    assign pc1 = r_pc + 16'd1;
    assign pc2 = r_pc + 16'd2;
    assign pc3 = r_pc + 16'd3;

    always_comb begin
        case (i_uword.addr_sel)
            AS_PC:   addr = r_pc[AW-1:0];
            AS_PC1:  addr = pc1[AW-1:0];
            AS_PC2:  addr = pc2[AW-1:0];
            AS_A:    addr = r_a[AW-1:0];
            AS_B:    addr = r_b[AW-1:0];
            AS_LOAD: addr = r_load_addr[AW-1:0];
            AS_CLR:  addr = r_clr;
            default: addr = r_pc[AW-1:0];
        endcase
    end

    assign diff = r_rdata - r_ma;

    always_comb begin
        case (i_uword.wd_sel)
            WD_ZERO:  wdata = '0;
            WD_LOAD:  wdata = r_load_word;
            WD_INPUT: wdata = r_in_eof ? NEG_ONE : {{(WORD_W-CHAR_W){1'b0}}, r_in_char};
            WD_DIFF:  wdata = diff;
            default:  wdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en && (i_uword.mem_op == MEM_WRITE))
            r_mem[addr] <= wdata;
        if (en && (i_uword.mem_op == MEM_READ))
            r_rdata <= r_mem[addr];
    end

    assign take_jump = diff[WORD_W-1] || (diff == '0);

    // result of a finishing step
    always_comb begin
        res_out_valid = 1'b0;
        res_out_char  = '0;
        res_in_taken  = 1'b0;
        res_npc       = r_pc;
        res_pc_upd    = 1'b0;
        case (i_uword.act)
            ACT_IN_DONE: begin
                res_in_taken = !r_in_eof;
                res_npc      = pc3;
                res_pc_upd   = 1'b1;
            end
            ACT_OUT_DONE: begin
                res_out_valid = 1'b1;
                res_out_char  = r_rdata[CHAR_W-1:0];
                res_npc       = pc3;
                res_pc_upd    = 1'b1;
            end
            ACT_SUB_DONE: begin
                res_npc    = take_jump ? r_c : pc3;
                res_pc_upd = 1'b1;
            end
            default: ;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr  <= '0;
            r_pc   <= '0;
            r_halt <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            if (en && (i_uword.act == ACT_CLR_INC))
                r_clr <= r_clr + 1'b1;
            if (en && res_pc_upd) begin
                r_pc   <= res_npc;
                r_halt <= res_npc[WORD_W-1];
            end
            if (en && emit)
                r_ov <= 1'b1;
            else if (o_result.ready)
                r_ov <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_load_addr <= i_item.load_addr;
            r_load_word <= i_item.load_word;
            r_in_char   <= i_item.in_char;
            r_in_eof    <= i_item.in_eof;
        end
        if (en) begin
            case (i_uword.latch)
                LT_A:    r_a  <= r_rdata;
                LT_B:    r_b  <= r_rdata;
                LT_C:    r_c  <= r_rdata;
                LT_MA:   r_ma <= r_rdata;
                default: ;
            endcase
        end
        if (en && emit) begin
            r_out_valid <= res_out_valid;
            r_out_char  <= res_out_char;
            r_in_taken  <= res_in_taken;
            r_halted    <= res_pc_upd ? res_npc[WORD_W-1] : r_halt;
            r_next_pc   <= res_npc;
        end
    end

    assign o_result.valid     = r_ov;
    assign o_result.out_valid = r_out_valid;
    assign o_result.out_char  = r_out_char;
    assign o_result.in_taken  = r_in_taken;
    assign o_result.halted    = r_halted;
    assign o_result.next_pc   = r_next_pc;

endmodule

>>> hw/rtl/subleq_processor.sv
// Steps per word, from the dispatch step that accepts it: a subtract does three fetches, two
// operand reads and a write-back; input or output does the fetches, a read at operand A and
// its finishing step; a load or halted step does only its finishing step. Words pass one at a
// time through the single-port memory: a new word is accepted only at dispatch, and a result
// still waiting holds the finishing step. Reset: i_rst_n synchronous, active low; pc and halt
// clear, then a clearing pass zeroes the memory before the first word is accepted.
module subleq_processor #(
    parameter int MEM_DEPTH = subleq_pkg::MEM_DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    subleq_in_if.sink    i_item,
    subleq_out_if.source o_result
);
    import subleq_pkg::*;

    t_uword    uword;
    t_seq_stat stat;

    subleq_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_uword (uword)
    );

    subleq_dp #(
        .MEM_DEPTH (MEM_DEPTH)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_uword  (uword),
        .o_stat   (stat),
        .i_item   (i_item),
        .o_result (o_result)
    );

endmodule

>>> test/subleq_processor_test_pkg.sv
`timescale 1ns / 1ps
// Request codes shared by the subleq_processor testbench files.
// No dependencies.
package subleq_processor_test_pkg;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_STEP = 1'b1;

endpackage

>>> test/subleq_processor_checker.sv
`timescale 1ns / 1ps
// Scoreboard for subleq_processor: mirrors word memory, pc and halt flag, predicts one
// result word per accepted request word and compares results in order.
// Depends on subleq_pkg, subleq_processor_test_pkg and the channel interfaces.
module subleq_processor_checker (
    input  logic  i_clk,
    input  logic  i_rst_n,
    subleq_in_if  i_item,
    subleq_out_if i_result,
    output int    o_fail_count,
    output int    o_outstanding
);
    import subleq_pkg::*;
    import subleq_processor_test_pkg::*;

    typedef struct packed {
        logic              out_valid;
        logic [CHAR_W-1:0] out_char;
        logic              in_taken;
        logic              halted;
        logic [WORD_W-1:0] next_pc;
    } t_step_result;

    logic [WORD_W-1:0] mirror_mem [0:MEM_DEPTH_DEF-1];
    logic [WORD_W-1:0] mirror_pc;
    logic              mirror_halted;
    t_step_result      pending_results [$];
    int                fail_count = 0;
    int                owed_count = 0;
    int                result_index = 0;

    assign o_fail_count  = fail_count;
    assign o_outstanding = owed_count;

    task automatic execute_word(input logic req, input logic [LOAD_ADDR_W-1:0] addr,
                                input logic [WORD_W-1:0] data,
                                input logic [CHAR_W-1:0] ch, input logic eof);
        logic [WORD_W-1:0]      op_a;
        logic [WORD_W-1:0]      op_b;
        logic [WORD_W-1:0]      op_c;
        logic [WORD_W-1:0]      diff;
        logic [WORD_W-1:0]      npc;
        logic [LOAD_ADDR_W-1:0] pc_addr;
        t_step_result           res;
        res = '0;
        if (req == REQ_LOAD) begin
            mirror_mem[addr] = data;
        end else if (!mirror_halted) begin
            pc_addr = mirror_pc[LOAD_ADDR_W-1:0];
            op_a = mirror_mem[pc_addr];
            op_b = mirror_mem[LOAD_ADDR_W'(pc_addr + 1)];
            op_c = mirror_mem[LOAD_ADDR_W'(pc_addr + 2)];
            npc  = mirror_pc + 16'd3;
            if (op_a == NEG_ONE) begin
                if (eof) begin
                    mirror_mem[op_b[LOAD_ADDR_W-1:0]] = NEG_ONE;
                end else begin
                    mirror_mem[op_b[LOAD_ADDR_W-1:0]] = {8'h00, ch};
                    res.in_taken = 1'b1;
                end
            end else if (op_b == NEG_ONE) begin
                res.out_valid = 1'b1;
                res.out_char  = mirror_mem[op_a[LOAD_ADDR_W-1:0]][CHAR_W-1:0];
            end else begin
                diff = mirror_mem[op_b[LOAD_ADDR_W-1:0]] - mirror_mem[op_a[LOAD_ADDR_W-1:0]];
                // branch on zero or sign bit set
                if (diff == '0 || diff[WORD_W-1]) begin
                    npc = op_c;
                end
                mirror_mem[op_b[LOAD_ADDR_W-1:0]] = diff;
            end
            mirror_pc = npc;
            if (mirror_pc[WORD_W-1]) begin
                mirror_halted = 1'b1;
            end
        end
        res.halted  = mirror_halted;
        res.next_pc = mirror_pc;
        pending_results.push_back(res);
    endtask

    task automatic compare_result();
        t_step_result want;
        t_step_result got;
        got = '{i_result.out_valid, i_result.out_char, i_result.in_taken,
                i_result.halted, i_result.next_pc};
        result_index++;
        if (pending_results.size() == 0) begin
            fail_count++;
            if (fail_count <= 10) begin
                $display("checker: result word %0d arrived with none owed (next_pc=%04h)",
                         result_index, got.next_pc);
            end
        end else begin
            want = pending_results.pop_front();
            if (got.out_valid !== want.out_valid || got.out_char !== want.out_char ||
                got.in_taken !== want.in_taken || got.halted !== want.halted ||
                got.next_pc !== want.next_pc) begin
                fail_count++;
                if (fail_count <= 10) begin
                    $display("checker: result word %0d mismatch", result_index);
                    $display("  want out_valid=%0b out_char=%02h in_taken=%0b halted=%0b pc=%04h",
                             want.out_valid, want.out_char, want.in_taken, want.halted,
                             want.next_pc);
                    $display("  got  out_valid=%0b out_char=%02h in_taken=%0b halted=%0b pc=%04h",
                             got.out_valid, got.out_char, got.in_taken, got.halted,
                             got.next_pc);
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MEM_DEPTH_DEF; i++) begin
                mirror_mem[i] = '0;
            end
            mirror_pc     = '0;
            mirror_halted = 1'b0;
            pending_results.delete();
        end else begin
            // a result never belongs to the word accepted on the same edge
            if (i_result.valid && i_result.ready) begin
                compare_result();
            end
            if (i_item.valid && i_item.ready) begin
                execute_word(i_item.req_type, i_item.load_addr, i_item.load_word,
                             i_item.in_char, i_item.in_eof);
            end
        end
        owed_count = pending_results.size();
    end

endmodule

>>> test/subleq_processor_test.sv
`timescale 1ns / 1ps
// Testbench top for subleq_processor: loads small programs, steps them under several
// idle patterns and gives the verdict. Depends on subleq_pkg, subleq_processor_test_pkg,
// the channel interfaces and subleq_processor_checker.
module subleq_processor_test;
    import subleq_pkg::*;
    import subleq_processor_test_pkg::*;

    localparam int RANDOM_ITEMS = 1920;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int TAIL_CYCLES  = 20;

    logic clk;
    logic rst_n;

    subleq_in_if  item_ch ();
    subleq_out_if result_ch ();

    int                sent_count    = 0;
    int                result_count  = 0;
    int                cycle_count   = 0;
    int                src_idle_pct  = 0;
    int                snk_stall_pct = 0;
    int                mismatch_total;
    int                results_owed;
    logic [WORD_W-1:0] last_pc = '0;
    logic [WORD_W-1:0] prog_pc = '0;

    subleq_processor dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_item   (item_ch),
        .o_result (result_ch)
    );

    subleq_processor_checker result_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_item        (item_ch),
        .i_result      (result_ch),
        .o_fail_count  (mismatch_total),
        .o_outstanding (results_owed)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        result_ch.ready = 1'b0;
        forever begin
            @(posedge clk);
            result_ch.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (result_ch.valid && result_ch.ready) begin
            result_count <= result_count + 1;
            last_pc      <= result_ch.next_pc;
        end
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[subleq_processor] ERROR");
            $finish;
        end
    end

    // Word at addr once the operand and instruction loads of one sequence are done.
    function automatic logic [WORD_W-1:0] staged_word(
        input logic [LOAD_ADDR_W-1:0] addr, input logic [LOAD_ADDR_W-1:0] pc,
        input logic [WORD_W-1:0] wa, wb, wc, va, vb);
        if (addr == pc) return wa;
        if (addr == LOAD_ADDR_W'(pc + 1)) return wb;
        if (addr == LOAD_ADDR_W'(pc + 2)) return wc;
        if (addr == wb[LOAD_ADDR_W-1:0]) return vb;
        return va;
    endfunction

    function automatic logic [WORD_W-1:0] branch_target(
        input logic [WORD_W-1:0] pc, input logic [WORD_W-1:0] wa, wb, wc, va, vb);
        logic [WORD_W-1:0] diff;
        diff = staged_word(wb[LOAD_ADDR_W-1:0], pc[LOAD_ADDR_W-1:0], wa, wb, wc, va, vb)
             - staged_word(wa[LOAD_ADDR_W-1:0], pc[LOAD_ADDR_W-1:0], wa, wb, wc, va, vb);
        if (wa == NEG_ONE || wb == NEG_ONE || (diff != '0 && !diff[WORD_W-1])) begin
            return pc + 16'd3;
        end
        return wc;
    endfunction

    function automatic logic [WORD_W-1:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return NEG_ONE;
            // point into the instruction itself, sometimes through the wrapped upper half
            1: return {1'($urandom), LOAD_ADDR_W'(prog_pc + $urandom_range(0, 2))};
            2, 3: return WORD_W'($urandom);
            default: return WORD_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [WORD_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return NEG_ONE;
            2: return 16'h8000;
            3: return 16'h7FFF;
            4: return 16'h0001;
            default: return WORD_W'($urandom);
        endcase
    endfunction

    function automatic logic [WORD_W-1:0] pick_target();
        case ($urandom_range(0, 9))
            0: return WORD_W'($urandom_range(32765, 32767));
            1: return WORD_W'($urandom_range(0, 255));
            default: return WORD_W'($urandom_range(0, 32767));
        endcase
    endfunction

    task automatic send_word(input logic req, input logic [LOAD_ADDR_W-1:0] addr,
                             input logic [WORD_W-1:0] data,
                             input logic [CHAR_W-1:0] ch, input logic eof);
        item_ch.valid     <= 1'b1;
        item_ch.req_type  <= req;
        item_ch.load_addr <= addr;
        item_ch.load_word <= data;
        item_ch.in_char   <= ch;
        item_ch.in_eof    <= eof;
        @(posedge clk);
        while (!item_ch.ready) @(posedge clk);
        sent_count++;
        // keep valid high when the next word follows at once
        if ($urandom_range(0, 99) < src_idle_pct) begin
            item_ch.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < src_idle_pct);
        end
    endtask

    task automatic load_at(input logic [LOAD_ADDR_W-1:0] addr, input logic [WORD_W-1:0] data);
        send_word(REQ_LOAD, addr, data, CHAR_W'($urandom), 1'($urandom));
    endtask

    task automatic wait_drain();
        item_ch.valid <= 1'b0;
        while (result_count != sent_count) @(posedge clk);
    endtask

    task automatic run_instr(input logic [WORD_W-1:0] wa, wb, wc, va, vb,
                             input bit load_ops, input logic [CHAR_W-1:0] ch,
                             input logic eof);
        logic [LOAD_ADDR_W-1:0] pc_addr;
        logic [WORD_W-1:0]      npc;
        pc_addr = prog_pc[LOAD_ADDR_W-1:0];
        npc = branch_target(prog_pc, wa, wb, wc, va, vb);
        if (load_ops) begin
            load_at(wa[LOAD_ADDR_W-1:0], va);
            load_at(wb[LOAD_ADDR_W-1:0], vb);
        end
        load_at(pc_addr, wa);
        load_at(LOAD_ADDR_W'(pc_addr + 1), wb);
        load_at(LOAD_ADDR_W'(pc_addr + 2), wc);
        send_word(REQ_STEP, LOAD_ADDR_W'($urandom), WORD_W'($urandom), ch, eof);
        if (load_ops || wa == NEG_ONE || wb == NEG_ONE) begin
            prog_pc = npc;
        end else begin
            // operands left as found: learn the branch from the block
            wait_drain();
            prog_pc = last_pc;
        end
    endtask

    task automatic random_instr();
        logic [WORD_W-1:0] wa;
        logic [WORD_W-1:0] wb;
        logic [WORD_W-1:0] wc;
        logic [WORD_W-1:0] va;
        logic [WORD_W-1:0] vb;
        bit                load_ops;
        bit                ok;
        int                n;
        if ($urandom_range(0, 7) == 0) begin
            n = $urandom_range(1, 3);
            repeat (n) load_at(LOAD_ADDR_W'($urandom), WORD_W'($urandom));
        end
        // redraw until the program cannot run off the top and halt early
        do begin
            wa = pick_operand();
            wb = pick_operand();
            wc = pick_target();
            va = pick_value();
            vb = ($urandom_range(0, 5) == 0) ? va : pick_value();
            load_ops = ($urandom_range(0, 9) != 0);
            if (load_ops || wa == NEG_ONE || wb == NEG_ONE) begin
                ok = branch_target(prog_pc, wa, wb, wc, va, vb) < 16'h8000;
            end else begin
                ok = prog_pc <= 16'd32764;
            end
        end while (!ok);
        run_instr(wa, wb, wc, va, vb, load_ops, CHAR_W'($urandom), $urandom_range(0, 3) == 0);
    endtask

    initial begin
        int phase_end;
        rst_n             = 1'b0;
        item_ch.valid     = 1'b0;
        item_ch.req_type  = REQ_LOAD;
        item_ch.load_addr = '0;
        item_ch.load_word = '0;
        item_ch.in_char   = '0;
        item_ch.in_eof    = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // input, then echo it back through an output instruction
        run_instr(NEG_ONE, 16'h0100, 16'h0000, '0, '0, 1'b0, 8'hA5, 1'b0);
        run_instr(16'h0100, NEG_ONE, 16'h0000, '0, '0, 1'b0, 8'h5A, 1'b0);
        // positive difference falls through, zero jumps near the top of memory
        run_instr(16'h0200, 16'h0201, 16'h0000, 16'h0001, 16'h0005, 1'b1, 8'h00, 1'b0);
        run_instr(16'h0202, 16'h0203, 16'd32766, NEG_ONE, NEG_ONE, 1'b1, 8'h00, 1'b0);
        // fetch wraps past the last word, operands wrap from the upper half, negative jump
        run_instr(16'h8123, 16'hC000, 16'h0040, 16'h8000, 16'h7FFF, 1'b1, 8'h33, 1'b0);
        // input at end of input
        run_instr(NEG_ONE, 16'h0204, 16'h0000, '0, '0, 1'b0, 8'hFF, 1'b1);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 49; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 49; end
                default: begin src_idle_pct = 14; snk_stall_pct = 14; end
            endcase
            phase_end = sent_count + RANDOM_ITEMS / 4;
            while (sent_count < phase_end) random_instr();
            wait_drain();
        end

        // jump to the highest target to halt, then step and load while halted
        run_instr({1'b0, LOAD_ADDR_W'(prog_pc + 3)}, {1'b0, LOAD_ADDR_W'(prog_pc + 4)},
                  NEG_ONE, 16'h1234, 16'h1234, 1'b1, 8'h00, 1'b0);
        send_word(REQ_STEP, LOAD_ADDR_W'($urandom), WORD_W'($urandom), 8'h41, 1'b0);
        send_word(REQ_STEP, LOAD_ADDR_W'($urandom), WORD_W'($urandom), 8'h42, 1'b1);
        load_at(LOAD_ADDR_W'($urandom), WORD_W'($urandom));
        send_word(REQ_STEP, LOAD_ADDR_W'($urandom), WORD_W'($urandom), 8'h43, 1'b0);

        wait_drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_total == 0 && results_owed == 0) begin
            $display("[subleq_processor] OK");
        end else begin
            $display("[subleq_processor] ERROR");
        end
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/subleq_pkg.sv
hw/rtl/subleq_if.sv
hw/rtl/subleq_seq.sv
hw/rtl/subleq_dp.sv
hw/rtl/subleq_processor.sv
test/subleq_processor_test_pkg.sv
test/subleq_processor_checker.sv
test/subleq_processor_test.sv
